// ===== rtl/bcd_pkg.sv =====
// types, constants and codes shared by the button click detector modules
// no dependencies
package bcd_pkg;

    // tick counter width and repeat-count ceiling
    localparam int TICK_WIDTH = 16;
    localparam int REPEAT_MAX = 15;
    localparam int REPEAT_W   = $clog2(REPEAT_MAX + 1);
    localparam int LIMIT_W    = 16;
    localparam int CMP_W      = (TICK_WIDTH > LIMIT_W) ? TICK_WIDTH : LIMIT_W;

    // port widths fixed by the interface
    localparam int DBC_W   = 4;
    localparam int CODE_W  = 4;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_SHORT    = 2'd1,
        CFG_LONG     = 2'd2,
        CFG_PRESSED  = 2'd3
    } t_cfg_idx;

    // event codes
    typedef enum logic [CODE_W-1:0] {
        EV_DOWN   = 4'd0,
        EV_UP     = 4'd1,
        EV_REPEAT = 4'd2,
        EV_SINGLE = 4'd3,
        EV_DOUBLE = 4'd4,
        EV_TRIPLE = 4'd5,
        EV_LSTART = 4'd6,
        EV_LHOLD  = 4'd7,
        EV_LSTOP  = 4'd8
    } t_evt_code;

    // click state machine, one-hot
    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_PRESSED   = 5'b00010,
        ST_RELEASED  = 5'b00100,
        ST_REPRESSED = 5'b01000,
        ST_LONG      = 5'b10000
    } t_state;

    // one result transaction
    typedef struct packed {
        t_evt_code          code;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_evt;

    // events produced by one tick, up to two
    typedef struct packed {
        logic [1:0] num;
        t_evt       ev0;
        t_evt       ev1;
    } t_evt_push;

endpackage

// ===== rtl/bcd_core.sv =====
// configuration registers, debounce filter and click state machine
// depends on bcd_pkg
module bcd_core
    import bcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_step,
    input  logic                  i_sample,
    output t_evt_push             o_push
);

    localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

    // configuration
    logic [DBC_W-1:0]   r_dbc_cnt;
    logic [LIMIT_W-1:0] r_short_limit;
    logic [LIMIT_W-1:0] r_long_limit;
    logic               r_pressed_level;

    // state
    t_state              r_state,    n_state;
    logic [TICK_WIDTH-1:0] r_tick,   n_tick;
    logic [DBC_W-1:0]    r_dbc,      n_dbc;
    logic                r_stable,   n_stable;
    logic [REPEAT_W-1:0] r_repeat,   n_repeat;

    logic [TICK_WIDTH-1:0] tick_inc;
    logic [DBC_W-1:0]      dbc_inc;
    logic                  down;
    logic                  gt_long;
    logic                  gt_short;
    logic                  lt_short;
    logic [1:0]            ev_num;
    t_evt_code             code0, code1;

    // tick counter and debounce filter
    always_comb begin
        tick_inc = r_tick;
        if (r_state != ST_IDLE && r_tick != TICK_MAX) begin
            tick_inc = r_tick + 1'b1;
        end
        dbc_inc  = r_dbc + 1'b1;
        n_stable = r_stable;
        n_dbc    = '0;
        if (i_sample != r_stable) begin
            if (dbc_inc >= r_dbc_cnt) begin
                n_stable = i_sample;
            end else begin
                n_dbc = dbc_inc;
            end
        end
    end

    assign down     = (n_stable == r_pressed_level);
    assign gt_long  = CMP_W'(tick_inc) > CMP_W'(r_long_limit);
    assign gt_short = CMP_W'(tick_inc) > CMP_W'(r_short_limit);
    assign lt_short = CMP_W'(tick_inc) < CMP_W'(r_short_limit);

    // click state machine
    always_comb begin
        n_state  = r_state;
        n_tick   = tick_inc;
        n_repeat = r_repeat;
        ev_num   = 2'd0;
        code0    = EV_DOWN;
        code1    = EV_DOWN;
        unique case (r_state)
            ST_IDLE: begin
                if (down) begin
                    n_repeat = REPEAT_W'(1);
                    ev_num   = 2'd1;
                    code0    = EV_DOWN;
                    n_tick   = '0;
                    n_state  = ST_PRESSED;
                end
            end
            ST_PRESSED: begin
                if (!down) begin
                    ev_num  = 2'd1;
                    code0   = EV_UP;
                    n_tick  = '0;
                    n_state = ST_RELEASED;
                end else if (gt_long) begin
                    ev_num  = 2'd1;
                    code0   = EV_LSTART;
                    n_state = ST_LONG;
                end
            end
            ST_RELEASED: begin
                if (down) begin
                    if (r_repeat < REPEAT_W'(REPEAT_MAX)) begin
                        n_repeat = r_repeat + 1'b1;
                    end
                    ev_num  = 2'd2;
                    code0   = EV_DOWN;
                    code1   = EV_REPEAT;
                    n_tick  = '0;
                    n_state = ST_REPRESSED;
                end else if (gt_short) begin
                    // four or more presses end silently
                    if (r_repeat == REPEAT_W'(1)) begin
                        ev_num = 2'd1;
                        code0  = EV_SINGLE;
                    end else if (r_repeat == REPEAT_W'(2)) begin
                        ev_num = 2'd1;
                        code0  = EV_DOUBLE;
                    end else if (r_repeat == REPEAT_W'(3)) begin
                        ev_num = 2'd1;
                        code0  = EV_TRIPLE;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_REPRESSED: begin
                if (!down) begin
                    ev_num = 2'd1;
                    code0  = EV_UP;
                    if (lt_short) begin
                        n_tick  = '0;
                        n_state = ST_RELEASED;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (gt_short) begin
                    // held second press turns into a plain press
                    n_state = ST_PRESSED;
                end
            end
            ST_LONG: begin
                if (down) begin
                    ev_num = 2'd1;
                    code0  = EV_LHOLD;
                end else begin
                    ev_num  = 2'd2;
                    code0   = EV_UP;
                    code1   = EV_LSTOP;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // events of this tick toward the result queue
    always_comb begin
        o_push.num       = i_step ? ev_num : 2'd0;
        o_push.ev0.code  = code0;
        o_push.ev0.count = COUNT_W'(n_repeat);
        o_push.ev0.last  = (ev_num == 2'd1);
        o_push.ev1.code  = code1;
        o_push.ev1.count = COUNT_W'(n_repeat);
        o_push.ev1.last  = 1'b1;
    end

    // configuration and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbc_cnt       <= DBC_W'(3);
            r_short_limit   <= LIMIT_W'(60);
            r_long_limit    <= LIMIT_W'(200);
            r_pressed_level <= 1'b0;
            r_state         <= ST_IDLE;
            r_tick          <= '0;
            r_dbc           <= '0;
            r_stable        <= 1'b1;
            r_repeat        <= '0;
        end else begin
            if (i_step) begin
                r_state  <= n_state;
                r_tick   <= n_tick;
                r_dbc    <= n_dbc;
                r_repeat <= n_repeat;
            end
            // a new active level reloads the filter to released
            if (i_cfg_we && t_cfg_idx'(i_cfg_idx) == CFG_PRESSED) begin
                r_stable <= ~i_cfg_data[0];
            end else if (i_step) begin
                r_stable <= n_stable;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_DEBOUNCE: r_dbc_cnt       <= i_cfg_data[DBC_W-1:0];
                    CFG_SHORT:    r_short_limit   <= i_cfg_data[LIMIT_W-1:0];
                    CFG_LONG:     r_long_limit    <= i_cfg_data[LIMIT_W-1:0];
                    CFG_PRESSED:  r_pressed_level <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // a press sequence always holds at least one press
    a_repeat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_repeat != '0)
        else $error("repeat count zero outside idle");

    // leaving long press always reports up and stop together
    a_long_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_state == ST_LONG && n_state == ST_IDLE |-> o_push.num == 2'd2)
        else $error("long press ended without up and stop");

    // the debounce counter clears before it can reach all ones
    a_dbc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dbc != '1)
        else $error("debounce counter passed its limit");

endmodule

// ===== rtl/bcd_evt_fifo.sv =====
// small result queue taking up to two events per cycle, one out per cycle
// depends on bcd_pkg
module bcd_evt_fifo
    import bcd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_evt_push i_push,
    output logic      o_room2,
    output logic      o_valid,
    input  logic      i_ready,
    output t_evt      o_evt
);

    t_evt               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0] r_count,  n_count;
    logic               pop;
    logic [FIFO_AW-1:0] wr_ptr1;

    assign o_valid = (r_count != '0);
    assign o_evt   = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    // room for two more after this cycle's pop
    assign o_room2 = (r_count - FIFO_CW'(pop)) <= FIFO_CW'(FIFO_DEPTH - 2);

    // pointer and fill updates
    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(i_push.num);
        n_rd_ptr = r_rd_ptr + FIFO_AW'(pop);
        n_count  = r_count + FIFO_CW'(i_push.num) - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.ev0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.ev1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != 2'd0 |-> o_room2)
        else $error("events pushed without room");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == $past(r_count) + FIFO_CW'($past(i_push.num))
                                      - FIFO_CW'($past(pop)))
        else $error("fill count out of step");

endmodule

// ===== rtl/button_click_detector_top.sv =====
// Button click detector. Each input transaction is one raw pin sample (one
// tick). The sample is registered, then debounced and run through the click state
// machine in the cycle it steps, which emits zero, one or two event
// transactions into a four-entry result queue; the last event of a tick has
// last_of_tick set. One sample is accepted per cycle as long as the queue can
// take two more events. The output side moves one event per cycle, so with it
// always ready the input runs at one tick per cycle except during quick
// repeated clicks, where ticks with two events (down and repeat) alternate
// with one-event ticks and the queue holds the input back now and then.
// Configuration writes are taken at any time but must only be issued while no
// tick is in flight; writing the pressed level also resets the debounced level
// to released.
// depends on bcd_pkg, bcd_core, bcd_evt_fifo
module button_click_detector_top
    import bcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_pin_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CODE_W-1:0]     o_event_code,
    output logic [COUNT_W-1:0]    o_click_count,
    output logic                  o_last_of_tick
);

    logic      r_in_valid, n_in_valid;
    logic      r_in_sample;
    logic      room2;
    logic      step;
    t_evt_push push;
    t_evt      evt;

    // input register: a held sample steps once the queue has room
    assign step       = r_in_valid && room2;
    assign o_in_ready = !r_in_valid || step;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_sample <= i_pin_sample;
        end
    end

    bcd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_sample   (r_in_sample),
        .o_push     (push)
    );

    bcd_evt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_evt   (evt)
    );

    // result transaction fields
    assign o_event_code   = evt.code;
    assign o_click_count  = evt.count;
    assign o_last_of_tick = evt.last;

endmodule

// ===== tb/sv/bcd_click_checker.sv =====
// event checker for the button click detector: predicts the event transactions
// caused by each accepted pin sample and compares the results in order
// depends on bcd_pkg
`timescale 1ns / 1ps
module bcd_click_checker
    import bcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_pin_sample,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [CODE_W-1:0]     i_event_code,
    input  logic [COUNT_W-1:0]    i_click_count,
    input  logic                  i_last_of_tick,
    output int                    o_fail_count,
    output int                    o_pending
);

    // register copies
    logic [DBC_W-1:0]      cfg_dbc;
    logic [LIMIT_W-1:0]    cfg_short;
    logic [LIMIT_W-1:0]    cfg_long;
    logic                  cfg_level;

    // predicted detector state
    t_state                click_state;
    logic [TICK_WIDTH-1:0] held_ticks;
    logic [DBC_W-1:0]      glitch_ticks;
    logic                  settled_level;
    logic [REPEAT_W-1:0]   press_total;

    t_evt expected_events[$];
    t_evt oldest;
    int   fails = 0;

    function automatic t_evt make_event(input t_evt_code code);
        t_evt ev;
        ev.code  = code;
        ev.count = COUNT_W'(press_total);
        ev.last  = 1'b0;
        return ev;
    endfunction

    // one tick: debounce, then the click state machine
    task automatic predict_tick(input logic level);
        t_evt tick_events[$];
        logic down;
        if (click_state != ST_IDLE && held_ticks != {TICK_WIDTH{1'b1}})
            held_ticks = held_ticks + 1'b1;

        if (level != settled_level) begin
            glitch_ticks = glitch_ticks + 1'b1;
            if (glitch_ticks >= cfg_dbc) begin
                settled_level = level;
                glitch_ticks  = '0;
            end
        end else begin
            glitch_ticks = '0;
        end

        down = (settled_level == cfg_level);

        case (click_state)
            ST_IDLE: begin
                if (down) begin
                    press_total = REPEAT_W'(1);
                    tick_events.push_back(make_event(EV_DOWN));
                    held_ticks  = '0;
                    click_state = ST_PRESSED;
                end
            end
            ST_PRESSED: begin
                if (!down) begin
                    tick_events.push_back(make_event(EV_UP));
                    held_ticks  = '0;
                    click_state = ST_RELEASED;
                end else if (held_ticks > cfg_long) begin
                    tick_events.push_back(make_event(EV_LSTART));
                    click_state = ST_LONG;
                end
            end
            ST_RELEASED: begin
                if (down) begin
                    if (press_total < REPEAT_MAX)
                        press_total = press_total + 1'b1;
                    tick_events.push_back(make_event(EV_DOWN));
                    tick_events.push_back(make_event(EV_REPEAT));
                    held_ticks  = '0;
                    click_state = ST_REPRESSED;
                end else if (held_ticks > cfg_short) begin
                    // four or more presses end silently
                    if (press_total == 1)
                        tick_events.push_back(make_event(EV_SINGLE));
                    else if (press_total == 2)
                        tick_events.push_back(make_event(EV_DOUBLE));
                    else if (press_total == 3)
                        tick_events.push_back(make_event(EV_TRIPLE));
                    click_state = ST_IDLE;
                end
            end
            ST_REPRESSED: begin
                if (!down) begin
                    tick_events.push_back(make_event(EV_UP));
                    if (held_ticks < cfg_short) begin
                        held_ticks  = '0;
                        click_state = ST_RELEASED;
                    end else begin
                        click_state = ST_IDLE;
                    end
                end else if (held_ticks > cfg_short) begin
                    // second press held too long turns into a plain press
                    click_state = ST_PRESSED;
                end
            end
            ST_LONG: begin
                if (down) begin
                    tick_events.push_back(make_event(EV_LHOLD));
                end else begin
                    tick_events.push_back(make_event(EV_UP));
                    tick_events.push_back(make_event(EV_LSTOP));
                    click_state = ST_IDLE;
                end
            end
            default: click_state = ST_IDLE;
        endcase

        if (tick_events.size() != 0)
            tick_events[tick_events.size() - 1].last = 1'b1;
        foreach (tick_events[k])
            expected_events.push_back(tick_events[k]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_dbc        = 4'd3;
            cfg_short      = 16'd60;
            cfg_long       = 16'd200;
            cfg_level      = 1'b0;
            click_state    = ST_IDLE;
            held_ticks     = '0;
            glitch_ticks   = '0;
            settled_level  = 1'b1;
            press_total    = '0;
            expected_events.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DEBOUNCE: cfg_dbc   = i_cfg_data[DBC_W-1:0];
                    CFG_SHORT:    cfg_short = i_cfg_data[LIMIT_W-1:0];
                    CFG_LONG:     cfg_long  = i_cfg_data[LIMIT_W-1:0];
                    CFG_PRESSED: begin
                        cfg_level     = i_cfg_data[0];
                        settled_level = ~i_cfg_data[0];
                    end
                    default: ;
                endcase
            end

            // compare the event transaction against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    $error("event_code %0d arrived with no event expected", i_event_code);
                    fails++;
                end else begin
                    oldest = expected_events.pop_front();
                    if (i_event_code !== oldest.code) begin
                        $error("event_code: expected %0d, actual %0d",
                               oldest.code, i_event_code);
                        fails++;
                    end
                    if (i_click_count !== oldest.count) begin
                        $error("click_count: expected %0d, actual %0d",
                               oldest.count, i_click_count);
                        fails++;
                    end
                    if (i_last_of_tick !== oldest.last) begin
                        $error("last_of_tick: expected %0d, actual %0d",
                               oldest.last, i_last_of_tick);
                        fails++;
                    end
                end
            end

            // sample transaction
            if (i_in_valid && i_in_ready)
                predict_tick(i_pin_sample);
        end
        o_pending    <= expected_events.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the button click detector: clock, reset, register writes,
// pin sample traffic with bursts and stalls, watchdog and verdict
// depends on bcd_pkg, button_click_detector_top, bcd_click_checker
`timescale 1ns / 1ps
module tb;
    import bcd_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT  = 3000;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_MOSTLY
    } t_ready_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_pin_sample;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [CODE_W-1:0]     o_event_code;
    logic [COUNT_W-1:0]    o_click_count;
    logic                  o_last_of_tick;

    int   fail_count;
    int   pending;
    logic hold_off_go;
    int   burst_left;
    int   samples_sent;
    int   stall_cycles = 0;

    // settings currently in the block, used to shape gestures
    logic [DBC_W-1:0]   cur_dbc;
    logic [LIMIT_W-1:0] cur_short;
    logic [LIMIT_W-1:0] cur_long;
    logic               cur_level;

    always #4 i_clk = ~i_clk;

    button_click_detector_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pin_sample   (i_pin_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_code   (o_event_code),
        .o_click_count  (o_click_count),
        .o_last_of_tick (o_last_of_tick)
    );

    bcd_click_checker click_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_pin_sample   (i_pin_sample),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_event_code   (o_event_code),
        .i_click_count  (o_click_count),
        .i_last_of_tick (o_last_of_tick),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // one sample transaction, with burst gaps in front of some
    task automatic offer_sample(input logic level);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_pin_sample <= level;
        do @(posedge i_clk); while (!o_in_ready);
        samples_sent++;
    endtask

    task automatic send_run(input logic level, input int count);
        repeat (count) offer_sample(level);
    endtask

    // stop offering until every event has come and the last tick has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // all four registers, with junk above the narrow fields
    task automatic write_config(input logic [DBC_W-1:0] dbc,
                                input logic [LIMIT_W-1:0] short_lim,
                                input logic [LIMIT_W-1:0] long_lim,
                                input logic level);
        logic [CFG_DATA_W-1:0] padded;
        padded = CFG_DATA_W'($urandom);
        padded[DBC_W-1:0] = dbc;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DEBOUNCE;
        i_cfg_data <= padded;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SHORT;
        i_cfg_data <= short_lim;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LONG;
        i_cfg_data <= long_lim;
        @(posedge i_clk);
        padded = CFG_DATA_W'($urandom);
        padded[0] = level;
        i_cfg_idx  <= CFG_PRESSED;
        i_cfg_data <= padded;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cur_dbc   = dbc;
        cur_short = short_lim;
        cur_long  = long_lim;
        cur_level = level;
    endtask

    // durations clustered around the limits, shifted by the debounce delay
    function automatic int pick_duration();
        int base;
        case ($urandom_range(0, 3))
            0:       base = $urandom_range(1, 4);
            1:       base = (cur_short > 200) ? 200 : int'(cur_short);
            2:       base = (cur_long > 250) ? 250 : int'(cur_long);
            default: base = $urandom_range(1, 40);
        endcase
        base = base + int'(cur_dbc) + int'($urandom_range(0, 4)) - 2;
        return (base < 1) ? 1 : base;
    endfunction

    // contact bounce shorter than the debounce count
    task automatic add_bounce(input logic level);
        if (cur_dbc > 1 && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_run(level, $urandom_range(1, cur_dbc - 1));
                send_run(!level, 1);
            end
        end
    endtask

    task automatic run_gesture();
        int press_len;
        int release_len;
        press_len   = pick_duration();
        release_len = pick_duration();
        add_bounce(cur_level);
        send_run(cur_level, press_len);
        add_bounce(!cur_level);
        send_run(!cur_level, release_len);
    endtask

    // receiver: stall pattern per segment, plus one long hold-off on request
    initial begin
        t_ready_mode mode;
        int          seg_left;
        int          hold_left;
        logic        hold_off_taken;
        mode           = READY_ALWAYS;
        seg_left       = 0;
        hold_left      = 0;
        hold_off_taken = 1'b0;
        i_out_ready    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                mode     = t_ready_mode'($urandom_range(0, 3));
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            if (hold_off_go && !hold_off_taken) begin
                hold_left      = HOLD_OFF_CYCLES;
                hold_off_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    READY_ALWAYS: i_out_ready <= 1'b1;
                    READY_HALF:   i_out_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:      i_out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        int phase_end;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_DEBOUNCE;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_pin_sample = 1'b0;
        hold_off_go  = 1'b0;
        burst_left   = 0;
        samples_sent = 0;
        cur_dbc      = 4'd3;
        cur_short    = 16'd60;
        cur_long     = 16'd200;
        cur_level    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: no debounce, tiny limits, active-high pin
        write_config(4'd0, 16'd2, 16'd2, 1'b1);
        // long press: down, long start, long hold, up and long stop
        send_run(1'b1, 5);
        send_run(1'b0, 1);
        // single click
        send_run(1'b1, 1);
        send_run(1'b0, 4);
        // triple click
        repeat (3) begin
            send_run(1'b1, 1);
            send_run(1'b0, 1);
        end
        send_run(1'b0, 3);
        // four presses time out with no click event
        repeat (4) begin
            send_run(1'b1, 1);
            send_run(1'b0, 1);
        end
        send_run(1'b0, 3);
        // second press held past the short limit becomes a long press
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 5);
        send_run(1'b0, 1);
        drain();

        // rapid clicks against a long receiver hold-off fill the result queue
        write_config(4'd0, 16'hFFFF, 16'hFFFF, 1'($urandom_range(0, 1)));
        hold_off_go <= 1'b1;
        repeat (20) begin
            send_run(cur_level, 1);
            send_run(!cur_level, 1);
        end
        drain();

        // random gestures under several register settings
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_config(4'd3, 16'd60, 16'd200, 1'b0);
                1: write_config(4'd0, 16'd0, 16'd0, 1'b1);
                2: write_config(4'd15, 16'hFFFF, 16'hFFFF, 1'($urandom_range(0, 1)));
                default: write_config(
                    ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(1, 4)),
                    16'($urandom_range(0, 25)),
                    16'($urandom_range(0, 50)),
                    1'($urandom_range(0, 1)));
            endcase
            phase_end = samples_sent + ((phase == 0) ? 300 : 140);
            while (samples_sent < phase_end) begin
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 20)) send_run(1'($urandom_range(0, 1)), 1);
                else
                    run_gesture();
            end
            drain();
        end

        @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bcd_pkg.sv
rtl/bcd_core.sv
rtl/bcd_evt_fifo.sv
rtl/button_click_detector_top.sv
tb/sv/bcd_click_checker.sv
tb/sv/tb.sv
